[src/tflut_pkg.sv]
`timescale 1ns / 1ps
// Package for the transfer-function interpolator: widths, request codes,
// controller states and the command and status words between the modules.
// It depends on nothing else.
package tflut_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int TABLE_ENTRIES  = 256;
    localparam int ONE_Q16        = 65536;
    localparam int FRAC_W         = 16;
    localparam int POS_W          = 17;
    localparam int VAL_W          = 16;
    localparam int PIU_W          = 5;
    localparam int PIU_RESET      = 2;
    localparam int IDX_W          = 4;
    localparam int ENTRY_W        = 8;
    localparam int NUM_CH         = 4;
    localparam int CH_W           = 2;
    localparam int Q_W            = 34;
    localparam int DIV_BITS       = 2;
    localparam int DIV_STEPS      = Q_W / DIV_BITS;
    localparam int DC_W           = $clog2(DIV_STEPS);
    localparam int ENTRY_SHIFT    = $clog2(ONE_Q16 / TABLE_ENTRIES);

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_DIV,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic wr_point;
        logic srch;
        logic div;
        logic mul;
        logic acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic seg_found;
        logic div_last;
        logic ch_last;
        logic out_free;
    } t_sts;

endpackage

[src/tflut_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module tflut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/tflut_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences search, division, interpolation and
// output hand-over. It depends on tflut_pkg.
module tflut_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_req_type,
    output logic            o_in_ready,
    input  tflut_pkg::t_sts i_sts,
    output tflut_pkg::t_cmd o_cmd
);

    import tflut_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == REQ_LOOKUP) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SRCH;
                    end else begin
                        o_cmd.wr_point = 1'b1;
                    end
                end
            end
            S_SRCH: begin
                o_cmd.srch = 1'b1;
                if (i_sts.seg_found) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.ch_last ? S_OUT : S_MUL;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/tflut_dp.sv]
`timescale 1ns / 1ps
// Datapath: point stores, segment search, radix-4 divider, shared multiplier
// with clamping, and the output register. It depends on tflut_pkg and tflut_ram.
module tflut_dp #(
    parameter int MAX_POINTS = tflut_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tflut_pkg::t_cmd               i_cmd,
    output tflut_pkg::t_sts               o_sts,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tflut_pkg::PIU_W-1:0]   i_cfg_data,
    input  logic [tflut_pkg::IDX_W-1:0]   i_point_index,
    input  logic [tflut_pkg::POS_W-1:0]   i_point_pos,
    input  logic [tflut_pkg::VAL_W-1:0]   i_point_alpha,
    input  logic [tflut_pkg::VAL_W-1:0]   i_point_red,
    input  logic [tflut_pkg::VAL_W-1:0]   i_point_green,
    input  logic [tflut_pkg::VAL_W-1:0]   i_point_blue,
    input  logic [tflut_pkg::ENTRY_W-1:0] i_entry_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tflut_pkg::VAL_W-1:0]   o_out_red,
    output logic [tflut_pkg::VAL_W-1:0]   o_out_green,
    output logic [tflut_pkg::VAL_W-1:0]   o_out_blue,
    output logic [tflut_pkg::VAL_W-1:0]   o_out_alpha,
    output logic                          o_zero_width
);

    import tflut_pkg::*;

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int NW      = $clog2(MAX_POINTS + 1);
    localparam int PA_W    = POS_W + VAL_W;
    localparam int COL_W   = 3 * VAL_W;
    localparam int REM_W   = POS_W + 1;
    localparam int PROD_W  = Q_W + VAL_W;
    localparam int ACC_W   = Q_W + 2;

    // Configuration register.
    logic [PIU_W-1:0] r_piu;
    logic [NW-1:0]    w_n;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (int'(r_piu) < 2) begin
            w_n = NW'(2);
        end else if (int'(r_piu) > MAX_POINTS) begin
            w_n = NW'(MAX_POINTS);
        end else begin
            w_n = NW'(r_piu);
        end
    end

    // Point stores.
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [POS_W-1:0]  w_pos_sat;
    logic [PA_W-1:0]   w_pa_rdata;
    logic [COL_W-1:0]  w_col_rdata;
    logic [AW-1:0]     r_addr_lo;
    logic [NW-1:0]     r_addr;

    assign w_we      = i_cmd.wr_point && (int'(i_point_index) < MAX_POINTS);
    assign w_waddr   = AW'(i_point_index);
    assign w_pos_sat = (i_point_pos > POS_W'(ONE_Q16)) ? POS_W'(ONE_Q16) : i_point_pos;
    assign r_addr_lo = r_addr[AW-1:0];
    assign w_raddr   = i_cmd.start ? '0 : r_addr_lo;

    tflut_ram #(
        .WIDTH (PA_W),
        .DEPTH (MAX_POINTS)
    ) u_pa_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({w_pos_sat, i_point_alpha}),
        .i_raddr (w_raddr),
        .o_rdata (w_pa_rdata)
    );

    tflut_ram #(
        .WIDTH (COL_W),
        .DEPTH (MAX_POINTS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_point_red, i_point_green, i_point_blue}),
        .i_raddr (w_raddr),
        .o_rdata (w_col_rdata)
    );

    // Sample position.
    logic [ENTRY_W-1:0] w_entry;
    logic [POS_W-1:0]   w_x;

    assign w_entry = (int'(i_entry_index) >= TABLE_ENTRIES) ?
                     ENTRY_W'(TABLE_ENTRIES - 1) : i_entry_index;
    assign w_x     = POS_W'(w_entry) << ENTRY_SHIFT;

    // Segment search.
    logic [POS_W-1:0]       r_x;
    logic [POS_W-1:0]       r_prev_pos;
    logic [VAL_W-1:0]       r_prev_val [NUM_CH];
    logic [VAL_W-1:0]       w_rd_val   [NUM_CH];
    logic [POS_W-1:0]       w_rd_pos;
    logic                   w_first;
    logic                   w_found;
    logic signed [POS_W:0]  w_num_s;
    logic signed [POS_W:0]  w_den_s;
    logic [POS_W-1:0]       w_num_mag;
    logic [POS_W-1:0]       w_den_mag;

    assign w_rd_pos    = w_pa_rdata[PA_W-1 -: POS_W];
    assign w_rd_val[0] = w_col_rdata[COL_W-1 -: VAL_W];
    assign w_rd_val[1] = w_col_rdata[2*VAL_W-1 -: VAL_W];
    assign w_rd_val[2] = w_col_rdata[VAL_W-1:0];
    assign w_rd_val[3] = w_pa_rdata[VAL_W-1:0];

    assign w_first = (r_addr == NW'(1));
    assign w_found = !w_first && ((w_rd_pos >= r_x) || (r_addr == w_n));

    assign w_num_s   = $signed({1'b0, r_x}) - $signed({1'b0, r_prev_pos});
    assign w_den_s   = $signed({1'b0, w_rd_pos}) - $signed({1'b0, r_prev_pos});
    assign w_num_mag = w_num_s[POS_W] ? POS_W'(-w_num_s) : POS_W'(w_num_s);
    assign w_den_mag = w_den_s[POS_W] ? POS_W'(-w_den_s) : POS_W'(w_den_s);

    // Divider, two quotient bits a cycle.
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] n_rem;
    logic [Q_W-1:0]   r_dvd;
    logic [Q_W-1:0]   n_dvd;
    logic [Q_W-1:0]   r_quo;
    logic [Q_W-1:0]   n_quo;
    logic [POS_W-1:0] r_dmag;
    logic             r_neg;
    logic             r_zw;
    logic [DC_W-1:0]  r_dcnt;

    always_comb begin
        logic [REM_W-1:0] v_trial;
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_quo = r_quo;
        for (int i = 0; i < DIV_BITS; i++) begin
            v_trial = {n_rem[REM_W-2:0], n_dvd[Q_W-1]};
            n_dvd   = {n_dvd[Q_W-2:0], 1'b0};
            if (v_trial >= {1'b0, r_dmag}) begin
                n_rem = v_trial - {1'b0, r_dmag};
                n_quo = {n_quo[Q_W-2:0], 1'b1};
            end else begin
                n_rem = v_trial;
                n_quo = {n_quo[Q_W-2:0], 1'b0};
            end
        end
    end

    // Interpolation, one channel at a time through a shared multiplier.
    logic [VAL_W-1:0]        r_lv [NUM_CH];
    logic [VAL_W-1:0]        r_rv [NUM_CH];
    logic [VAL_W-1:0]        r_res [NUM_CH];
    logic [CH_W-1:0]         r_ch;
    logic [VAL_W-1:0]        w_v0;
    logic [VAL_W-1:0]        w_v1;
    logic signed [VAL_W:0]   w_diff;
    logic [VAL_W-1:0]        w_dmag;
    logic [Q_W-1:0]          w_tmag;
    logic [PROD_W-1:0]       w_prod;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_psign;
    logic [Q_W-1:0]          w_mag;
    logic signed [ACC_W-1:0] w_term;
    logic signed [ACC_W-1:0] w_sum;
    logic [VAL_W-1:0]        w_clamp;

    assign w_v0   = r_lv[r_ch];
    assign w_v1   = r_rv[r_ch];
    assign w_diff = $signed({1'b0, w_v1}) - $signed({1'b0, w_v0});
    assign w_dmag = w_diff[VAL_W] ? VAL_W'(-w_diff) : VAL_W'(w_diff);
    assign w_tmag = r_zw ? '0 : r_quo;
    assign w_prod = PROD_W'(w_tmag) * PROD_W'(w_dmag);

    assign w_mag  = r_prod[PROD_W-1:FRAC_W];
    assign w_term = r_psign ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag});
    assign w_sum  = w_term + $signed(ACC_W'(w_v0));

    always_comb begin
        if (w_sum[ACC_W-1]) begin
            w_clamp = '0;
        end else if (|w_sum[ACC_W-2:VAL_W]) begin
            w_clamp = '1;
        end else begin
            w_clamp = w_sum[VAL_W-1:0];
        end
    end

    // Output register.
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_red;
    logic [VAL_W-1:0] r_out_green;
    logic [VAL_W-1:0] r_out_blue;
    logic [VAL_W-1:0] r_out_alpha;
    logic             r_out_zw;

    assign o_sts.seg_found = i_cmd.srch && w_found;
    assign o_sts.div_last  = (r_dcnt == DC_W'(DIV_STEPS - 1));
    assign o_sts.ch_last   = (r_ch == CH_W'(NUM_CH - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu       <= PIU_W'(PIU_RESET);
            r_addr      <= '0;
            r_dcnt      <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_piu <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_addr <= NW'(1);
                r_ch   <= '0;
            end else if (i_cmd.srch && !w_found) begin
                r_addr <= r_addr + NW'(1);
            end
            if (i_cmd.srch && w_found) begin
                r_dcnt <= '0;
            end else if (i_cmd.div) begin
                r_dcnt <= r_dcnt + DC_W'(1);
            end
            if (i_cmd.acc) begin
                r_ch <= r_ch + CH_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x <= w_x;
        end
        if (i_cmd.srch) begin
            if (w_found) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_lv[c] <= r_prev_val[c];
                    r_rv[c] <= w_rd_val[c];
                end
                r_dvd  <= Q_W'({w_num_mag, {FRAC_W{1'b0}}});
                r_dmag <= w_den_mag;
                r_rem  <= '0;
                r_quo  <= '0;
                r_neg  <= w_num_s[POS_W] ^ w_den_s[POS_W];
                r_zw   <= (w_den_s == '0);
            end else begin
                r_prev_pos <= w_rd_pos;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_prev_val[c] <= w_rd_val[c];
                end
            end
        end
        if (i_cmd.div) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
            r_quo <= n_quo;
        end
        if (i_cmd.mul) begin
            r_prod  <= w_prod;
            r_psign <= r_neg ^ w_diff[VAL_W];
        end
        if (i_cmd.acc) begin
            r_res[r_ch] <= w_clamp;
        end
        if (i_cmd.out_load) begin
            r_out_red   <= r_res[0];
            r_out_green <= r_res[1];
            r_out_blue  <= r_res[2];
            r_out_alpha <= r_res[3];
            r_out_zw    <= r_zw;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_red;
    assign o_out_green  = r_out_green;
    assign o_out_blue   = r_out_blue;
    assign o_out_alpha  = r_out_alpha;
    assign o_zero_width = r_out_zw;

    a_srch_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srch |-> (r_addr != '0) && (r_addr <= w_n))
        else $error("Search address outside the points in use.");

    a_div_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |-> (r_ch == '0))
        else $error("Channel counter not cleared before division.");

    a_zw_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul && r_zw) |=> (r_prod == '0))
        else $error("Zero-width segment gave a non-zero product.");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("Output word overwritten before it was taken.");

endmodule

[src/transfer_function_lut_interpolator.sv]
`timescale 1ns / 1ps
// Piecewise-linear transfer-function lookup; top level over tflut_ctrl and tflut_dp.
// A point write gives no word. A lookup of a position in segment k searches the points,
// one point per cycle over the store read port, then runs the divider and interpolates
// each channel in turn through the multiply and accumulate states; the next request can be
// accepted in the cycle after the result word is loaded.
// Reset clears the controller and sets points_in_use to 2; the point stores are not cleared.
module transfer_function_lut_interpolator #(
    parameter int MAX_POINTS = tflut_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [tflut_pkg::IDX_W-1:0]   i_point_index,
    input  logic [tflut_pkg::POS_W-1:0]   i_point_pos,
    input  logic [tflut_pkg::VAL_W-1:0]   i_point_alpha,
    input  logic [tflut_pkg::VAL_W-1:0]   i_point_red,
    input  logic [tflut_pkg::VAL_W-1:0]   i_point_green,
    input  logic [tflut_pkg::VAL_W-1:0]   i_point_blue,
    input  logic [tflut_pkg::ENTRY_W-1:0] i_entry_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tflut_pkg::VAL_W-1:0]   o_out_red,
    output logic [tflut_pkg::VAL_W-1:0]   o_out_green,
    output logic [tflut_pkg::VAL_W-1:0]   o_out_blue,
    output logic [tflut_pkg::VAL_W-1:0]   o_out_alpha,
    output logic                          o_zero_width,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tflut_pkg::PIU_W-1:0]   i_cfg_data
);

    import tflut_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    tflut_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tflut_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_point_index (i_point_index),
        .i_point_pos   (i_point_pos),
        .i_point_alpha (i_point_alpha),
        .i_point_red   (i_point_red),
        .i_point_green (i_point_green),
        .i_point_blue  (i_point_blue),
        .i_entry_index (i_entry_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha),
        .o_zero_width  (o_zero_width)
    );

endmodule
